// ===== src/sef_pkg.sv =====
// ----------------------------------------------------------------------------
// sef_pkg
// Shared types and constants for the spectrum edge finder.
// ----------------------------------------------------------------------------
package sef_pkg;
    localparam int CENTER_W  = 19;
    localparam int COUNT_W   = 24;
    localparam int NOM_W     = 20;
    localparam int MINE_W    = 24;
    localparam int SLOPE_W   = 48;
    localparam int SUM_W     = 32;
    localparam int FA_W      = 40;
    localparam int FB_W      = 32;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_NOM_ANNI = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOM_DEEX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ENT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_EDGE = 2'd3;

    localparam logic [NOM_W-1:0]    NOM_ANNI_RST = 20'd140000;
    localparam logic [NOM_W-1:0]    NOM_DEEX_RST = 20'd200000;
    localparam logic [MINE_W-1:0]   MIN_ENT_RST  = 24'd100;
    localparam logic [CENTER_W-1:0] DEF_EDGE_RST = 19'd399000;

    localparam logic signed [SLOPE_W-1:0] SLOPE_INIT = 48'sd655360000;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ORDER = 2'd2;

    localparam int QDEPTH = 2;

    // work handed from front to back
    typedef struct packed {
        logic                 pt_valid;
        logic [CENTER_W-1:0]  dh;
        logic signed [COUNT_W:0] dc;
        logic [CENTER_W-1:0]  pos;
        logic                 last;
        logic [SUM_W-1:0]     sum;
        logic [CENTER_W-1:0]  def_edge;
    } t_job;
endpackage

// ===== src/sef_bin_if.sv =====
// ----------------------------------------------------------------------------
// sef_bin_if
// Input channel: histogram bin words.
// ----------------------------------------------------------------------------
interface sef_bin_if;
    logic                          valid;
    logic                          ready;
    logic [sef_pkg::CENTER_W-1:0]  bin_center;
    logic [sef_pkg::COUNT_W-1:0]   bin_count;
    logic                          last_bin;
    modport source (output valid, bin_center, bin_count, last_bin, input ready);
    modport sink   (input valid, bin_center, bin_count, last_bin, output ready);
endinterface

// ===== src/sef_res_if.sv =====
// ----------------------------------------------------------------------------
// sef_res_if
// Output channel: calibration result words.
// ----------------------------------------------------------------------------
interface sef_res_if;
    logic                                valid;
    logic                                ready;
    logic [sef_pkg::FA_W-1:0]            factor_a;
    logic signed [sef_pkg::FB_W-1:0]     factor_b;
    logic [sef_pkg::CENTER_W-1:0]        anni_edge;
    logic [sef_pkg::CENTER_W-1:0]        deex_edge;
    logic [sef_pkg::STATUS_W-1:0]        status;
    modport source (output valid, factor_a, factor_b, anni_edge, deex_edge, status,
                    input ready);
    modport sink   (input valid, factor_a, factor_b, anni_edge, deex_edge, status,
                    output ready);
endinterface

// ===== src/sef_front.sv =====
// ----------------------------------------------------------------------------
// sef_front
// Accepts bin words, forms differences, midpoint and the running count sum.
// ----------------------------------------------------------------------------
module sef_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [sef_pkg::CENTER_W-1:0] i_def_edge,
    sef_bin_if.sink                     bin,
    output logic                        o_push,
    output sef_pkg::t_job               o_job,
    input  logic                        i_full
);
    logic [sef_pkg::CENTER_W-1:0] r_prev_center;
    logic [sef_pkg::COUNT_W-1:0]  r_prev_count;
    logic                         r_have_prev;
    logic [sef_pkg::SUM_W-1:0]    r_sum;
    logic [sef_pkg::SUM_W:0]      sum_ext;
    logic [sef_pkg::SUM_W-1:0]    n_sum;
    logic [sef_pkg::CENTER_W:0]   mid;

    assign bin.ready = !i_full;
    assign o_push    = bin.valid && !i_full;
    assign sum_ext   = {1'b0, r_sum} + {{(sef_pkg::SUM_W+1-sef_pkg::COUNT_W){1'b0}},
                                        bin.bin_count};
    assign n_sum     = sum_ext[sef_pkg::SUM_W] ? '1 : sum_ext[sef_pkg::SUM_W-1:0];
    assign mid       = {1'b0, bin.bin_center} + {1'b0, r_prev_center};

    always_comb begin
        o_job.pt_valid = r_have_prev && (bin.bin_center > r_prev_center);
        o_job.dh       = bin.bin_center - r_prev_center;
        o_job.dc       = $signed({1'b0, bin.bin_count}) - $signed({1'b0, r_prev_count});
        o_job.pos      = mid[sef_pkg::CENTER_W:1];
        o_job.last     = bin.last_bin;
        o_job.sum      = n_sum;
        o_job.def_edge = i_def_edge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_center <= '0;
            r_prev_count  <= '0;
            r_have_prev   <= 1'b0;
            r_sum         <= '0;
        end else if (o_push) begin
            r_prev_center <= bin.bin_center;
            r_prev_count  <= bin.bin_count;
            r_have_prev   <= !bin.last_bin;
            r_sum         <= bin.last_bin ? '0 : n_sum;
        end
    end
endmodule

// ===== src/sef_queue.sv =====
// ----------------------------------------------------------------------------
// sef_queue
// Short FIFO between front and back.
// ----------------------------------------------------------------------------
module sef_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sef_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output sef_pkg::t_job o_job
);
    localparam int AW = $clog2(sef_pkg::QDEPTH);
    sef_pkg::t_job  r_mem [sef_pkg::QDEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(sef_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

// ===== src/sef_div.sv =====
// ----------------------------------------------------------------------------
// sef_div
// Restoring divider, one quotient bit a cycle, unsigned magnitudes.
// ----------------------------------------------------------------------------
module sef_div #(
    parameter int NW = 64,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW+1);
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    assign trial  = {r_rem, r_q[NW-1]};
    assign diff   = trial - {1'b0, r_den};
    assign o_quo  = r_q;
    assign o_done = r_busy && (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
            r_q    <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
                if (!diff[DW]) begin
                    r_rem <= diff[DW-1:0];
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= trial[DW-1:0];
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
            end
        end
    end
endmodule

// ===== src/sef_back.sv =====
// ----------------------------------------------------------------------------
// sef_back
// Slope division, minimum tracking and final factor calculation.
// ----------------------------------------------------------------------------
module sef_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  sef_pkg::t_job                i_job,
    output logic                         o_pop,
    input  logic [sef_pkg::NOM_W-1:0]    i_nom_anni,
    input  logic [sef_pkg::NOM_W-1:0]    i_nom_deex,
    input  logic [sef_pkg::MINE_W-1:0]   i_min_ent,
    sef_res_if.source                    res
);
    localparam int DNW = 64;
    localparam int DDW = 20;
    localparam int CW  = sef_pkg::CENTER_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SDIV, S_TAKE, S_FIN, S_MUL, S_NUM, S_ADIV, S_BDIV, S_OUT
    } t_state;

    t_state r_state;
    logic signed [sef_pkg::SLOPE_W-1:0] r_min_a, r_min_b;
    logic [CW-1:0]  r_edge_a, r_edge_b;
    logic           r_neg;
    logic [DNW-1:0] r_fa_q;
    logic [DDW-1:0] r_d;
    logic [39:0]    r_p1, r_p2;
    logic signed [42:0] r_num;
    logic           r_valid;
    logic [sef_pkg::FA_W-1:0]        r_fa;
    logic signed [sef_pkg::FB_W-1:0] r_fb;
    logic [sef_pkg::STATUS_W-1:0]    r_status;

    logic           div_start, div_done;
    logic [DNW-1:0] div_num, div_quo;
    logic [DDW-1:0] div_den;
    logic [CW-1:0]  ea, eb;
    logic signed [sef_pkg::SLOPE_W-1:0] slope;
    logic [DNW-1:0] mag;
    logic [42:0]    num_mag;
    logic [DNW-1:0] fb_mag;

    sef_div #(.NW(DNW), .DW(DDW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

    assign ea = r_edge_a;
    assign eb = r_edge_b;
    assign mag     = r_neg ? -div_quo : div_quo;
    assign slope   = sef_pkg::SLOPE_W'($signed(mag));
    assign num_mag = r_num[42] ? 43'(-r_num) : 43'(r_num);
    assign fb_mag  = r_neg ? -div_quo : div_quo;

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        o_pop     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_empty && i_job.pt_valid) begin
                    div_start = 1'b1;
                    div_num   = DNW'(i_job.dc[sef_pkg::COUNT_W] ? -i_job.dc : i_job.dc) << 16;
                    div_den   = DDW'(i_job.dh);
                end
            end
            S_NUM: begin
                div_start = 1'b1;
                div_num   = {i_nom_anni, 16'h0, 28'h0} >> 28;
                div_den   = r_d;
            end
            S_ADIV: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_num   = DNW'(num_mag);
                    div_den   = r_d;
                end
            end
            S_TAKE:  o_pop = !i_job.last;
            S_OUT:   o_pop = !r_valid;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_edge_a <= sef_pkg::DEF_EDGE_RST;
            r_edge_b <= sef_pkg::DEF_EDGE_RST;
            r_min_a  <= sef_pkg::SLOPE_INIT;
            r_min_b  <= sef_pkg::SLOPE_INIT;
        end else begin
            if (res.ready && r_valid) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_neg   <= i_job.dc[sef_pkg::COUNT_W];
                        r_state <= i_job.pt_valid ? S_SDIV : S_TAKE;
                    end
                end
                S_SDIV: begin
                    if (div_done) begin
                        if (slope < r_min_a) begin
                            r_min_a  <= slope;
                            r_edge_a <= i_job.pos;
                        end
                        r_state <= S_TAKE;
                    end
                end
                S_TAKE: begin
                    r_state <= i_job.last ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    r_fa     <= '0;
                    r_fb     <= '0;
                    r_d      <= DDW'(eb) - DDW'(ea);
                    if (i_job.sum < {8'h0, i_min_ent}) begin
                        r_status <= sef_pkg::ST_FEW;
                        r_state  <= S_OUT;
                    end else if (eb <= ea) begin
                        r_status <= sef_pkg::ST_ORDER;
                        r_state  <= S_OUT;
                    end else begin
                        r_status <= sef_pkg::ST_OK;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_p1    <= 40'(i_nom_deex) * 40'(r_d);
                    r_p2    <= 40'(i_nom_anni) * 40'(ea);
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_num   <= $signed({3'b0, r_p1}) - $signed({3'b0, r_p2});
                    r_state <= S_ADIV;
                end
                S_ADIV: begin
                    if (div_done) begin
                        r_fa_q  <= div_quo;
                        r_neg   <= r_num[42];
                        r_state <= S_BDIV;
                    end
                end
                S_BDIV: begin
                    if (div_done) begin
                        r_fa <= (r_fa_q > DNW'({sef_pkg::FA_W{1'b1}})) ? '1
                                : r_fa_q[sef_pkg::FA_W-1:0];
                        if (!r_neg && div_quo > 64'h7FFF_FFFF)
                            r_fb <= 32'sh7FFF_FFFF;
                        else if (r_neg && div_quo > 64'h8000_0000)
                            r_fb <= -32'sh7FFF_FFFF - 32'sd1;
                        else
                            r_fb <= fb_mag[sef_pkg::FB_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_valid) begin
                        r_valid         <= 1'b1;
                        res.anni_edge   <= ea;
                        res.deex_edge   <= eb;
                        res.factor_a    <= r_fa;
                        res.factor_b    <= r_fb;
                        res.status      <= r_status;
                        r_edge_a        <= i_job.def_edge;
                        r_edge_b        <= i_job.def_edge;
                        r_min_a         <= sef_pkg::SLOPE_INIT;
                        r_min_b         <= sef_pkg::SLOPE_INIT;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // deexcitation tracking uses the updated anni edge
            if (r_state == S_SDIV && div_done) begin
                if ((2 * {2'b0, i_job.pos}) >
                    (3 * {2'b0, (slope < r_min_a) ? i_job.pos : ea})
                    && slope < r_min_b) begin
                    r_min_b  <= slope;
                    r_edge_b <= i_job.pos;
                end
            end
        end
    end

    assign res.valid = r_valid;
endmodule

// ===== src/spectrum_edge_finder.sv =====
// ----------------------------------------------------------------------------
// spectrum_edge_finder
// Edge search over histogram bins and calibration factor calculation.
// ----------------------------------------------------------------------------
// Each bin with a slope point passes through the bit-serial 64-bit divider in the
// back end; other bins only pass through the take state.
// The last bin adds the two factor divisions, which are skipped when the status
// is not ok, plus any wait for the previous result to be taken.
// The front takes a word per cycle until the two-entry queue fills.
// Synchronous active-low reset restores registers and clears the run state.
module spectrum_edge_finder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sef_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sef_pkg::CFG_W-1:0]         i_cfg_data,
    sef_bin_if.sink                           bin,
    sef_res_if.source                         res
);
    logic [sef_pkg::NOM_W-1:0]    r_nom_anni, r_nom_deex;
    logic [sef_pkg::MINE_W-1:0]   r_min_ent;
    logic [sef_pkg::CENTER_W-1:0] r_def_edge;
    logic          push, pop, full, empty;
    sef_pkg::t_job fjob, qjob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nom_anni <= sef_pkg::NOM_ANNI_RST;
            r_nom_deex <= sef_pkg::NOM_DEEX_RST;
            r_min_ent  <= sef_pkg::MIN_ENT_RST;
            r_def_edge <= sef_pkg::DEF_EDGE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sef_pkg::CFG_NOM_ANNI: r_nom_anni <= i_cfg_data[sef_pkg::NOM_W-1:0];
                sef_pkg::CFG_NOM_DEEX: r_nom_deex <= i_cfg_data[sef_pkg::NOM_W-1:0];
                sef_pkg::CFG_MIN_ENT:  r_min_ent  <= i_cfg_data[sef_pkg::MINE_W-1:0];
                sef_pkg::CFG_DEF_EDGE: r_def_edge <= i_cfg_data[sef_pkg::CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    sef_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_def_edge(r_def_edge),
        .bin       (bin),
        .o_push    (push),
        .o_job     (fjob),
        .i_full    (full)
    );

    sef_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (fjob),
        .o_full (full),
        .i_pop  (pop),
        .o_empty(empty),
        .o_job  (qjob)
    );

    sef_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .i_job     (qjob),
        .o_pop     (pop),
        .i_nom_anni(r_nom_anni),
        .i_nom_deex(r_nom_deex),
        .i_min_ent (r_min_ent),
        .res       (res)
    );
endmodule
